// File: hw/rtl/pidc_pkg.sv
// ============================================================================
// PID controller package
// Shared widths, codes, request structs and state encoding for the clamped
// PID controller.
// ============================================================================
`default_nettype none

package pidc_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int DT_W    = 31;
    localparam int DIV_W   = DATA_W + FRAC_W;
    localparam int REG_NUM = 7;
    localparam int IDX_W   = 3;

    localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_INTEG_MIN = 3'd3,
        REG_INTEG_MAX = 3'd4,
        REG_OUT_MIN   = 3'd5,
        REG_OUT_MAX   = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_MIN  = 2'd1,
        CLAMP_MAX  = 2'd2
    } t_clamp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_E_DT,
        S_INTEG_ADD,
        S_INTEG_BND,
        S_MUL_I,
        S_ADD_I,
        S_WAIT_DIV,
        S_ADD_D,
        S_SAT_CMD,
        S_CLAMP_CMD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                     en;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [DATA_W-1:0] mag;
        logic [DT_W-1:0]   dt;
    } t_div_req;

endpackage

`default_nettype wire

// File: hw/rtl/pid_controller_clamped.sv
// ============================================================================
// Clamped PID controller
// Signed Q16.16 PID update with integrator clamp and command clamp, built
// around one shared multiplier and a serial divider under a sequencer.
// ============================================================================
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: err_in, step_time, integ_load
//                                             tuser: op
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: command, integ_now, clamp_state
// cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// An update request is paced by the 48-step serial divider that forms the
// derivative; a load request does not use the divider.
// The block accepts one request at a time and is ready again once the result
// sits in the output register, so a stalled output holds only the next result.
// Reset clears the configuration registers, integrator and previous error.
// ============================================================================
`default_nettype none

module pid_controller_clamped
    import pidc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [95:0]       s_axis_tdata,  // err_in, step_time, integ_load
    input  wire logic              s_axis_tuser,  // op
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [71:0]            m_axis_tdata,  // command, integ_now, clamp_state
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [DATA_W-1:0] i_cfg_data
);

    t_state                    r_state;
    t_state                    n_state;
    logic signed [DATA_W-1:0]  r_cfg [REG_NUM];
    logic signed [DATA_W-1:0]  r_err;
    logic [DT_W-1:0]           r_dt;
    logic signed [DATA_W-1:0]  r_prev;
    logic signed [DATA_W-1:0]  r_integ;
    logic signed [DATA_W+1:0]  r_sum;
    logic signed [DATA_W-1:0]  r_cmd;
    t_clamp                    r_cstate;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_o_cmd;
    logic signed [DATA_W-1:0]  r_o_integ;
    t_clamp                    r_o_cstate;

    logic                      w_accept;
    logic                      w_in_op;
    logic signed [DATA_W-1:0]  w_in_err;
    logic [DT_W-1:0]           w_in_dt;
    logic signed [DATA_W-1:0]  w_in_load;
    logic [DT_W-1:0]           w_dt_fix;
    logic signed [DATA_W:0]    w_diff;
    logic [DATA_W:0]           w_mag;
    logic                      w_out_free;
    t_mul_req                  w_mul_req;
    logic signed [DATA_W-1:0]  w_mul_res;
    t_div_req                  w_div_req;
    logic                      w_div_done;
    logic signed [DATA_W-1:0]  w_div_quot;

    function automatic logic signed [DATA_W-1:0] f_sat(input logic signed [DATA_W+1:0] x);
        logic [2:0] top;
        top = x[DATA_W+1:DATA_W-1];
        if ((&top) || !(|top)) begin
            return x[DATA_W-1:0];
        end else if (x[DATA_W+1]) begin
            return VAL_MIN;
        end else begin
            return VAL_MAX;
        end
    endfunction

    assign w_in_err  = s_axis_tdata[DATA_W-1:0];
    assign w_in_dt   = s_axis_tdata[DATA_W+DT_W-1:DATA_W];
    assign w_in_load = s_axis_tdata[2*DATA_W+DT_W-1:DATA_W+DT_W];
    assign w_in_op   = s_axis_tuser;
    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_dt_fix  = (w_in_dt == '0) ? DT_W'(1) : w_in_dt;
    assign w_diff    = {w_in_err[DATA_W-1], w_in_err} - {r_prev[DATA_W-1], r_prev};
    assign w_mag     = w_diff[DATA_W] ? (~w_diff + 1'b1) : w_diff;
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_o_cstate, r_o_integ, r_o_cmd};

    pidc_mul u_mul (
        .i_clk (i_clk),
        .i_req (w_mul_req),
        .o_res (w_mul_res)
    );

    pidc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_in_op == OP_LOAD) ? S_DONE : S_MUL_E_DT;
                end
            end
            S_MUL_E_DT:  n_state = S_INTEG_ADD;
            S_INTEG_ADD: n_state = S_INTEG_BND;
            S_INTEG_BND: n_state = S_MUL_I;
            S_MUL_I:     n_state = S_ADD_I;
            S_ADD_I:     n_state = S_WAIT_DIV;
            S_WAIT_DIV: begin
                if (w_div_done) begin
                    n_state = S_ADD_D;
                end
            end
            S_ADD_D:     n_state = S_SAT_CMD;
            S_SAT_CMD:   n_state = S_CLAMP_CMD;
            S_CLAMP_CMD: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready   = 1'b0;
        w_mul_req       = '0;
        w_div_req.start = 1'b0;
        w_div_req.neg   = w_diff[DATA_W];
        w_div_req.mag   = w_mag[DATA_W-1:0];
        w_div_req.dt    = w_dt_fix;
        case (r_state)
            S_IDLE: begin
                s_axis_tready   = 1'b1;
                w_div_req.start = s_axis_tvalid && (w_in_op == OP_UPDATE);
            end
            S_MUL_E_DT: begin
                w_mul_req.en = 1'b1;
                w_mul_req.a  = r_err;
                w_mul_req.b  = {1'b0, r_dt};
            end
            S_INTEG_ADD: begin
                w_mul_req.en = 1'b1;
                w_mul_req.a  = r_err;
                w_mul_req.b  = r_cfg[REG_GAIN_P];
            end
            S_MUL_I: begin
                w_mul_req.en = 1'b1;
                w_mul_req.a  = r_integ;
                w_mul_req.b  = r_cfg[REG_GAIN_I];
            end
            S_WAIT_DIV: begin
                w_mul_req.en = w_div_done;
                w_mul_req.a  = w_div_quot;
                w_mul_req.b  = r_cfg[REG_GAIN_D];
            end
            default: begin
                w_mul_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_NUM; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < IDX_W'(REG_NUM))) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_integ <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_in_op == OP_LOAD) begin
                            r_integ <= w_in_load;
                        end else begin
                            r_prev <= w_in_err;
                        end
                    end
                end
                S_INTEG_ADD: begin
                    r_integ <= f_sat({{2{r_integ[DATA_W-1]}}, r_integ}
                                     + {{2{w_mul_res[DATA_W-1]}}, w_mul_res});
                end
                S_INTEG_BND: begin
                    if (r_integ > r_cfg[REG_INTEG_MAX]) begin
                        r_integ <= r_cfg[REG_INTEG_MAX];
                    end else if (r_integ < r_cfg[REG_INTEG_MIN]) begin
                        r_integ <= r_cfg[REG_INTEG_MIN];
                    end
                end
                default: begin
                    r_integ <= r_integ;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_err    <= w_in_err;
                r_dt     <= w_dt_fix;
                r_cmd    <= '0;
                r_cstate <= CLAMP_NONE;
            end
            S_INTEG_BND: begin
                r_sum <= {{2{w_mul_res[DATA_W-1]}}, w_mul_res};
            end
            S_ADD_I, S_ADD_D: begin
                r_sum <= r_sum + {{2{w_mul_res[DATA_W-1]}}, w_mul_res};
            end
            S_SAT_CMD: begin
                r_cmd <= f_sat(r_sum);
            end
            S_CLAMP_CMD: begin
                if (r_cmd <= r_cfg[REG_OUT_MIN]) begin
                    r_cmd    <= r_cfg[REG_OUT_MIN];
                    r_cstate <= CLAMP_MIN;
                end else if (r_cmd >= r_cfg[REG_OUT_MAX]) begin
                    r_cmd    <= r_cfg[REG_OUT_MAX];
                    r_cstate <= CLAMP_MAX;
                end
            end
            default: begin
                r_cmd <= r_cmd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_o_cmd    <= r_cmd;
            r_o_integ  <= r_integ;
            r_o_cstate <= r_cstate;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("Accepted request did not start the sequencer.");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("Result appeared without a finished request.");

    a_deriv_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_D) |-> $past(w_div_done))
        else $error("Derivative term used before the divider finished.");

    a_min_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_o_cstate == CLAMP_MIN)) |-> (r_o_cmd == r_cfg[REG_OUT_MIN]))
        else $error("Minimum clamp reported with a different command.");

endmodule

`default_nettype wire

// File: hw/rtl/pidc_mul.sv
// ============================================================================
// PID shared multiplier
// Registered signed product, then floor shift by the fraction width and
// saturation to the data width.
// ============================================================================
`default_nettype none

module pidc_mul
    import pidc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_mul_req                 i_req,
    output logic signed [DATA_W-1:0]      o_res
);

    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [2*DATA_W-1:0] w_shift;
    logic [DATA_W:0]            w_top;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= $signed(i_req.a) * $signed(i_req.b);
        end
    end

    always_comb begin
        w_shift = r_prod >>> FRAC_W;
        w_top   = w_shift[2*DATA_W-1:DATA_W-1];
        if ((&w_top) || !(|w_top)) begin
            o_res = w_shift[DATA_W-1:0];
        end else if (w_shift[2*DATA_W-1]) begin
            o_res = VAL_MIN;
        end else begin
            o_res = VAL_MAX;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pidc_div.sv
// ============================================================================
// PID serial divider
// Restoring division of the error change, scaled by the fraction width, by
// the time step, one quotient bit per cycle, with signed saturation.
// ============================================================================
`default_nettype none

module pidc_div
    import pidc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_div_req            i_req,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [DT_W-1:0]  r_dt;
    logic [DT_W-1:0]  r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DT_W:0]    w_rem_sh;
    logic [DT_W+1:0]  w_sub;
    logic             w_ge;
    logic             w_big;

    assign w_rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign w_sub    = {1'b0, w_rem_sh} - {2'b00, r_dt};
    assign w_ge     = !w_sub[DT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.neg;
            r_dt  <= i_req.dt;
            r_rem <= '0;
            r_quo <= {i_req.mag, {FRAC_W{1'b0}}};
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DT_W-1:0] : w_rem_sh[DT_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign w_big  = |r_quo[DIV_W-1:DATA_W-1];

    always_comb begin
        if (r_neg) begin
            o_quot = w_big ? VAL_MIN : (~r_quo[DATA_W-1:0] + 1'b1);
        end else begin
            o_quot = w_big ? VAL_MAX : r_quo[DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire
